[src/hwm_pkg.sv]
package hwm_pkg;

    // Scanner modes, one-hot
    typedef enum logic [4:0] {
        MODE_TEXT     = 5'b00001,
        MODE_TAG      = 5'b00010,
        MODE_COMMENT  = 5'b00100,
        MODE_PRESERVE = 5'b01000,
        MODE_ENDTAG   = 5'b10000
    } t_mode;

    // Tag name scan phases
    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_IN     = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;

    // Preserved element kinds
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_PRE      = 3'd1;
    localparam logic [2:0] KIND_CODE     = 3'd2;
    localparam logic [2:0] KIND_TEXTAREA = 3'd3;
    localparam logic [2:0] KIND_SCRIPT   = 3'd4;
    localparam logic [2:0] KIND_STYLE    = 3'd5;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int NAME_DEPTH  = 8;
    localparam int QUEUE_DEPTH = 3;

    // One input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       doc_last;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       run_last;
        logic       doc_end;
    } t_out_item;

    // Results released by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  res0;
        t_out_item  res1;
    } t_step_res;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_low(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
               (c >= 8'h41 && c <= 8'h5a) || c == CH_DASH || c == 8'h5f || c == 8'h3a;
    endfunction

    function automatic logic [3:0] kind_len(input logic [2:0] k);
        logic [3:0] len;
        case (k)
            KIND_PRE:      len = 4'd3;
            KIND_CODE:     len = 4'd4;
            KIND_TEXTAREA: len = 4'd8;
            KIND_SCRIPT:   len = 4'd6;
            KIND_STYLE:    len = 4'd5;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    // Lowercase element names, zero past the end
    function automatic logic [7:0] kind_char(input logic [2:0] k, input logic [2:0] idx);
        logic [63:0] s;
        case (k)
            KIND_PRE:      s = {"pre", 40'h0};
            KIND_CODE:     s = {"code", 32'h0};
            KIND_TEXTAREA: s = "textarea";
            KIND_SCRIPT:   s = {"script", 16'h0};
            KIND_STYLE:    s = {"style", 24'h0};
            default:       s = 64'h0;
        endcase
        return s[(7 - idx) * 8 +: 8];
    endfunction

    // Expected byte of the comment opener at a given prefix position
    function automatic logic [7:0] comment_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd1:    ch = CH_BANG;
            3'd2:    ch = CH_DASH;
            3'd3:    ch = CH_DASH;
            default: ch = CH_LT;
        endcase
        return ch;
    endfunction

endpackage

[src/hwm_in_if.sv]
interface hwm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       doc_last;

    modport source (output valid, output in_byte, output doc_last, input ready);
    modport sink (input valid, input in_byte, input doc_last, output ready);
endinterface

[src/hwm_out_if.sv]
interface hwm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       doc_end;

    modport source (output valid, output out_byte, output out_valid, output run_last,
                    output doc_end, input ready);
    modport sink (input valid, input out_byte, input out_valid, input run_last,
                  input doc_end, output ready);
endinterface

[src/hwm_parser.sv]
module hwm_parser
    import hwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_step_res o_res
);

    // Scanner state
    t_mode       r_mode, n_mode;
    logic        r_quote_open, n_quote_open;
    logic [7:0]  r_quote_char, n_quote_char;
    logic [3:0]  r_name_count, n_name_count;
    logic        r_name_long, n_name_long;
    logic [1:0]  r_name_phase, n_name_phase;
    logic        r_closing, n_closing;
    logic        r_slash, n_slash;
    logic [2:0]  r_kind, n_kind;
    logic [3:0]  r_cm, n_cm;
    logic        r_pending, n_pending;
    logic        r_run_text, n_run_text;
    logic        r_prev_tag, n_prev_tag;
    logic [2:0]  r_prefix, n_prefix;
    logic [1:0]  r_dash, n_dash;

    // Tag name buffer, no reset; only entries below the count are read
    logic [7:0]  r_name [NAME_DEPTH];
    logic        name_we;

    logic [7:0]  c;
    logic        c_ws;
    logic [5:0]  kind_hit;
    logic [2:0]  found;
    logic        name_ok;

    // Compare the stored name against each preserved element name
    always_comb begin
        kind_hit = '0;
        for (int k = 1; k <= 5; k++) begin
            kind_hit[k] = (r_name_count == kind_len(3'(k)));
            for (int i = 0; i < NAME_DEPTH; i++) begin
                if (4'(i) < kind_len(3'(k)) && r_name[i] != kind_char(3'(k), 3'(i)))
                    kind_hit[k] = 1'b0;
            end
        end
        name_ok = !r_closing && !r_slash && !r_name_long && (r_name_count != 4'd0);
        found = KIND_NONE;
        if (name_ok) begin
            if (kind_hit[1])      found = KIND_PRE;
            else if (kind_hit[2]) found = KIND_CODE;
            else if (kind_hit[3]) found = KIND_TEXTAREA;
            else if (kind_hit[4]) found = KIND_SCRIPT;
            else if (kind_hit[5]) found = KIND_STYLE;
        end
    end

    assign c    = i_item.in_byte;
    assign c_ws = is_ws(c);

    // Next state and released bytes for one input byte
    always_comb begin
        logic       first, gt_close, ok, term;
        logic [4:0] cnt_lim;
        logic [3:0] cnt;
        logic [1:0] nres;
        logic [7:0] b0, b1;
        logic       marker;

        n_mode       = r_mode;
        n_quote_open = r_quote_open;
        n_quote_char = r_quote_char;
        n_name_count = r_name_count;
        n_name_long  = r_name_long;
        n_name_phase = r_name_phase;
        n_closing    = r_closing;
        n_slash      = r_slash;
        n_kind       = r_kind;
        n_cm         = r_cm;
        n_pending    = r_pending;
        n_run_text   = r_run_text;
        n_prev_tag   = r_prev_tag;
        n_prefix     = r_prefix;
        n_dash       = r_dash;
        name_we      = 1'b0;
        first        = (r_prefix == 3'd1);
        gt_close     = 1'b0;
        ok           = 1'b0;
        term         = 1'b0;
        cnt_lim      = 5'd2 + {1'b0, kind_len(r_kind)};
        cnt          = r_cm;
        nres         = 2'd1;
        b0           = c;
        b1           = c;
        marker       = 1'b0;

        case (r_mode)
            MODE_TAG: begin
                // comment opener tracking
                if (r_prefix >= 3'd1 && r_prefix <= 3'd3) begin
                    if (c == comment_char(r_prefix)) n_prefix = r_prefix + 3'd1;
                    else n_prefix = 3'd0;
                end
                // tag name capture
                if (r_name_phase == PH_BEFORE) begin
                    if (first && c == CH_SLASH) begin
                        n_closing = 1'b1;
                    end else if (c_ws) begin
                        n_name_phase = r_name_phase;
                    end else if (is_name(c)) begin
                        name_we      = (r_name_count < 4'(NAME_DEPTH));
                        n_name_phase = PH_IN;
                    end else begin
                        n_name_phase = PH_AFTER;
                    end
                end else if (r_name_phase == PH_IN) begin
                    if (is_name(c)) name_we = (r_name_count < 4'(NAME_DEPTH));
                    else n_name_phase = PH_AFTER;
                end
                if (((r_name_phase == PH_BEFORE && !(first && c == CH_SLASH) && !c_ws) ||
                     r_name_phase == PH_IN) && is_name(c)) begin
                    if (name_we) n_name_count = r_name_count + 4'd1;
                    else n_name_long = 1'b1;
                end
                if (n_prefix == 3'd4) begin
                    n_mode = MODE_COMMENT;
                    n_dash = 2'd0;
                end else begin
                    if (r_quote_open) begin
                        if (c == r_quote_char) n_quote_open = 1'b0;
                    end else if (c == CH_DQ || c == CH_SQ) begin
                        n_quote_open = 1'b1;
                        n_quote_char = c;
                    end else if (c == CH_GT) begin
                        gt_close = 1'b1;
                    end
                    if (gt_close) begin
                        n_mode       = MODE_TEXT;
                        n_pending    = 1'b0;
                        n_run_text   = 1'b0;
                        n_prev_tag   = 1'b1;
                        n_quote_open = 1'b0;
                        if (found != KIND_NONE) begin
                            n_mode = MODE_PRESERVE;
                            n_kind = found;
                            n_cm   = 4'd0;
                        end
                    end else if (!c_ws) begin
                        n_slash = (c == CH_SLASH);
                    end
                end
            end
            MODE_COMMENT: begin
                if (c == CH_DASH) begin
                    if (r_dash < 2'd2) n_dash = r_dash + 2'd1;
                end else if (c == CH_GT && r_dash >= 2'd2) begin
                    n_mode       = MODE_TEXT;
                    n_pending    = 1'b0;
                    n_run_text   = 1'b0;
                    n_prev_tag   = 1'b1;
                    n_quote_open = 1'b0;
                end else begin
                    n_dash = 2'd0;
                end
            end
            MODE_PRESERVE: begin
                // close tag matcher: '<', '/', name, then a terminator
                if ({1'b0, r_cm} >= cnt_lim) begin
                    term = c_ws || c == CH_GT || c == CH_SLASH || c == CH_NUL;
                    if (term) begin
                        cnt = 4'd0;
                        if (c == CH_GT) begin
                            n_mode       = MODE_TEXT;
                            n_pending    = 1'b0;
                            n_run_text   = 1'b0;
                            n_prev_tag   = 1'b1;
                            n_quote_open = 1'b0;
                            n_kind       = KIND_NONE;
                        end else begin
                            n_mode       = MODE_ENDTAG;
                            n_quote_open = 1'b0;
                        end
                    end else begin
                        cnt = {3'd0, c == CH_LT};
                    end
                end else begin
                    if (r_cm == 4'd0)      ok = (c == CH_LT);
                    else if (r_cm == 4'd1) ok = (c == CH_SLASH);
                    else ok = (to_low(c) == kind_char(r_kind, 3'(r_cm - 4'd2)));
                    cnt = ok ? r_cm + 4'd1 : {3'd0, c == CH_LT};
                end
                n_cm = cnt;
            end
            MODE_ENDTAG: begin
                if (r_quote_open) begin
                    if (c == r_quote_char) n_quote_open = 1'b0;
                end else if (c == CH_DQ || c == CH_SQ) begin
                    n_quote_open = 1'b1;
                    n_quote_char = c;
                end else if (c == CH_GT) begin
                    n_mode       = MODE_TEXT;
                    n_pending    = 1'b0;
                    n_run_text   = 1'b0;
                    n_prev_tag   = 1'b1;
                    n_quote_open = 1'b0;
                    n_kind       = KIND_NONE;
                end
            end
            default: begin
                // text: collapse whitespace runs
                if (c == CH_LT) begin
                    if (r_pending && r_run_text) begin
                        nres = 2'd2;
                        b0   = CH_SPACE;
                    end
                    n_mode       = MODE_TAG;
                    n_quote_open = 1'b0;
                    n_name_count = 4'd0;
                    n_name_long  = 1'b0;
                    n_name_phase = PH_BEFORE;
                    n_closing    = 1'b0;
                    n_slash      = 1'b0;
                    n_prefix     = 3'd1;
                    n_prev_tag   = 1'b1;
                    n_pending    = 1'b0;
                    n_run_text   = 1'b0;
                end else if (c_ws) begin
                    nres      = 2'd0;
                    n_pending = 1'b1;
                end else begin
                    if (r_pending) begin
                        nres = 2'd2;
                        b0   = CH_SPACE;
                    end
                    n_pending  = 1'b0;
                    n_run_text = 1'b1;
                end
            end
        endcase

        // Document end: trailing space, end marker, back to reset state
        if (i_item.doc_last) begin
            if (n_mode == MODE_TEXT && n_pending && (n_run_text || !n_prev_tag) &&
                nres == 2'd0) begin
                nres = 2'd1;
                b0   = CH_SPACE;
            end
            if (nres == 2'd0) begin
                nres   = 2'd1;
                marker = 1'b1;
                b0     = 8'h00;
            end
            n_mode       = MODE_TEXT;
            n_quote_open = 1'b0;
            n_quote_char = 8'h00;
            n_name_count = 4'd0;
            n_name_long  = 1'b0;
            n_name_phase = PH_BEFORE;
            n_closing    = 1'b0;
            n_slash      = 1'b0;
            n_kind       = KIND_NONE;
            n_cm         = 4'd0;
            n_pending    = 1'b0;
            n_run_text   = 1'b0;
            n_prev_tag   = 1'b0;
            n_prefix     = 3'd0;
            n_dash       = 2'd0;
        end

        o_res.cnt            = nres;
        o_res.res0.out_byte  = b0;
        o_res.res0.out_valid = !marker;
        o_res.res0.run_last  = (nres == 2'd1);
        o_res.res0.doc_end   = (nres == 2'd1) && i_item.doc_last;
        o_res.res1.out_byte  = b1;
        o_res.res1.out_valid = 1'b1;
        o_res.res1.run_last  = 1'b1;
        o_res.res1.doc_end   = i_item.doc_last;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_TEXT;
            r_quote_open <= 1'b0;
            r_quote_char <= 8'h00;
            r_name_count <= 4'd0;
            r_name_long  <= 1'b0;
            r_name_phase <= PH_BEFORE;
            r_closing    <= 1'b0;
            r_slash      <= 1'b0;
            r_kind       <= KIND_NONE;
            r_cm         <= 4'd0;
            r_pending    <= 1'b0;
            r_run_text   <= 1'b0;
            r_prev_tag   <= 1'b0;
            r_prefix     <= 3'd0;
            r_dash       <= 2'd0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_quote_open <= n_quote_open;
            r_quote_char <= n_quote_char;
            r_name_count <= n_name_count;
            r_name_long  <= n_name_long;
            r_name_phase <= n_name_phase;
            r_closing    <= n_closing;
            r_slash      <= n_slash;
            r_kind       <= n_kind;
            r_cm         <= n_cm;
            r_pending    <= n_pending;
            r_run_text   <= n_run_text;
            r_prev_tag   <= n_prev_tag;
            r_prefix     <= n_prefix;
            r_dash       <= n_dash;
        end
    end

    // Name buffer write, lowercased
    always_ff @(posedge i_clk) begin
        if (i_accept && name_we) begin
            r_name[r_name_count[2:0]] <= to_low(c);
        end
    end

endmodule

[src/hwm_outq.sv]
module hwm_outq
    import hwm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_step_res        i_res,
    output logic             o_room,
    hwm_out_if.source        o_out
);

    // Three-slot shift queue; slot 0 drives the port
    t_out_item   r_slot [QUEUE_DEPTH];
    t_out_item   n_slot [QUEUE_DEPTH];
    t_out_item   shifted [QUEUE_DEPTH];
    logic [1:0]  r_count, n_count;
    logic [1:0]  base;
    logic [1:0]  push_n;
    logic        pop;

    assign pop    = (r_count != 2'd0) && o_out.ready;
    assign base   = r_count - {1'b0, pop};
    assign push_n = i_push ? i_res.cnt : 2'd0;
    assign n_count = base + push_n;
    assign o_room = (r_count <= 2'd1);

    always_comb begin
        shifted[0] = pop ? r_slot[1] : r_slot[0];
        shifted[1] = pop ? r_slot[2] : r_slot[1];
        shifted[2] = r_slot[2];
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slot[i] = shifted[i];
            if (2'(i) == base && push_n != 2'd0)
                n_slot[i] = i_res.res0;
            else if (2'(i) == base + 2'd1 && push_n == 2'd2)
                n_slot[i] = i_res.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 2'd0;
        else          r_count <= n_count;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) r_slot[i] <= n_slot[i];
    end

    assign o_out.valid     = (r_count != 2'd0);
    assign o_out.out_byte  = r_slot[0].out_byte;
    assign o_out.out_valid = r_slot[0].out_valid;
    assign o_out.run_last  = r_slot[0].run_last;
    assign o_out.doc_end   = r_slot[0].doc_end;

endmodule

[src/html_whitespace_minifier.sv]
// HTML whitespace minifier. Takes one document byte per transaction (doc_last on the
// final byte) and returns the minified bytes: whitespace runs in text collapse to one
// space, runs that hold only whitespace next to a tag are dropped, and tags, comments
// and pre/code/textarea/script/style bodies pass through unchanged. Each input byte
// yields zero, one or two result transactions; run_last marks the last one, and the
// document's final byte always yields a result with doc_end set (out_valid low if it
// carries no byte). The parser state updates in the cycle a byte is accepted, so one
// byte is taken every cycle while the output side keeps up. Results wait in a
// three-entry output queue; input ready is high while it holds at most one result,
// so a byte that releases two results can hold off the next byte. All state
// returns to reset after the last byte, ready for the next document.
module html_whitespace_minifier
    import hwm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    hwm_in_if.sink    i_in,
    hwm_out_if.source o_out
);

    t_in_item  item;
    t_step_res step_res;
    logic      room;
    logic      accept;

    assign item.in_byte  = i_in.in_byte;
    assign item.doc_last = i_in.doc_last;
    assign i_in.ready    = room;
    assign accept        = i_in.valid && room;

    // Byte scanner and minify decisions
    hwm_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_res    (step_res)
    );

    // Result queue toward the output port
    hwm_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (step_res),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

[src/hwm_checker.sv]
module hwm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_vld,
    input logic       i_out_rdy,
    input logic [7:0] i_out_byte,
    input logic       i_out_valid,
    input logic       i_run_last,
    input logic       i_doc_end
);

    // An empty result is only ever the document end marker
    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_vld && !i_out_valid) |-> (i_doc_end && i_run_last && i_out_byte == 8'h00))
        else $error("empty result that is not the document end marker");

    // The final result of a document also closes its byte's run
    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_vld && i_doc_end) |-> i_run_last)
        else $error("doc_end without run_last");

    // A result that is not the last of its run is always followed by its partner,
    // which closes the run
    a_pair_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_vld && i_out_rdy && !i_run_last) |=> (i_out_vld && i_run_last))
        else $error("second result of a byte missing");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_vld && !i_out_rdy) |=>
            (i_out_vld && $stable(i_out_byte) && $stable(i_out_valid) &&
             $stable(i_run_last) && $stable(i_doc_end)))
        else $error("output result changed while stalled");

endmodule

bind html_whitespace_minifier hwm_checker u_hwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_vld   (o_out.valid),
    .i_out_rdy   (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_valid (o_out.out_valid),
    .i_run_last  (o_out.run_last),
    .i_doc_end   (o_out.doc_end)
);

[tb/tb_html_whitespace_minifier.sv]
`timescale 1ns / 100ps

module tb_html_whitespace_minifier;
    import hwm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1100;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hwm_in_if  in_if ();
    hwm_out_if out_if ();

    html_whitespace_minifier i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shared run state
    bit         idle_on = 1'b1;
    int         holds_asked = 0;
    int         holds_done = 0;
    int         bytes_sent = 0;
    int         mismatches = 0;
    t_out_item  expected_out[$];
    logic [7:0] doc_q[$];

    // Scanner mirror, updated on every accepted input transaction
    t_mode      sc_mode;
    logic       sc_quoted;
    logic [7:0] sc_quote_ch;
    logic [7:0] sc_name[NAME_DEPTH];
    logic [3:0] sc_name_len;
    logic       sc_name_long;
    logic [1:0] sc_name_ph;
    logic       sc_closing;
    logic       sc_slash_end;
    logic [2:0] sc_kind;
    logic [3:0] sc_close_pos;
    logic       sc_space;
    logic       sc_run_text;
    logic       sc_after_tag;
    logic [2:0] sc_opener;
    logic [1:0] sc_dashes;
    t_out_item  step_outs[2];
    int         step_cnt;

    //--------------------------------------------------------------------
    // Byte classes and element names
    //--------------------------------------------------------------------
    function automatic logic ws_byte(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c | 8'h20;
        return c;
    endfunction

    function automatic logic name_byte(input logic [7:0] c);
        logic [7:0] l;
        l = lower_byte(c);
        return (l >= "a" && l <= "z") || (c >= "0" && c <= "9") ||
               c == "-" || c == "_" || c == ":";
    endfunction

    function automatic string elem_name(input logic [2:0] k);
        case (k)
            KIND_PRE:      return "pre";
            KIND_CODE:     return "code";
            KIND_TEXTAREA: return "textarea";
            KIND_SCRIPT:   return "script";
            KIND_STYLE:    return "style";
            default:       return "";
        endcase
    endfunction

    //--------------------------------------------------------------------
    // Minifier prediction
    //--------------------------------------------------------------------
    function automatic void put(input logic [7:0] c);
        if (step_cnt < 2) begin
            step_outs[step_cnt] = '{out_byte: c, out_valid: 1'b1, run_last: 1'b0,
                                    doc_end: 1'b0};
            step_cnt++;
        end
    endfunction

    function automatic void reset_scanner();
        sc_mode      = MODE_TEXT;
        sc_quoted    = 1'b0;
        sc_quote_ch  = '0;
        foreach (sc_name[i]) sc_name[i] = '0;
        sc_name_len  = '0;
        sc_name_long = 1'b0;
        sc_name_ph   = PH_BEFORE;
        sc_closing   = 1'b0;
        sc_slash_end = 1'b0;
        sc_kind      = KIND_NONE;
        sc_close_pos = '0;
        sc_space     = 1'b0;
        sc_run_text  = 1'b0;
        sc_after_tag = 1'b0;
        sc_opener    = '0;
        sc_dashes    = '0;
    endfunction

    function automatic void enter_text();
        sc_mode      = MODE_TEXT;
        sc_space     = 1'b0;
        sc_run_text  = 1'b0;
        sc_after_tag = 1'b1;
        sc_quoted    = 1'b0;
    endfunction

    function automatic void keep_name_byte(input logic [7:0] c);
        if (sc_name_len < NAME_DEPTH) begin
            sc_name[sc_name_len[2:0]] = lower_byte(c);
            sc_name_len++;
        end else begin
            sc_name_long = 1'b1;
        end
    endfunction

    // Tag closed by '>': an opening tag with a known short name starts a body
    function automatic void close_tag();
        logic [2:0] hit;
        string      nm;
        bit         same;
        hit = KIND_NONE;
        if (!sc_closing && !sc_slash_end && !sc_name_long && sc_name_len != 0) begin
            for (int k = KIND_PRE; k <= KIND_STYLE; k++) begin
                nm = elem_name(k[2:0]);
                if (nm.len() == sc_name_len && hit == KIND_NONE) begin
                    same = 1'b1;
                    for (int i = 0; i < nm.len(); i++)
                        if (nm[i] != sc_name[i]) same = 1'b0;
                    if (same) hit = k[2:0];
                end
            end
        end
        enter_text();
        if (hit != KIND_NONE) begin
            sc_mode      = MODE_PRESERVE;
            sc_kind      = hit;
            sc_close_pos = '0;
        end
    endfunction

    function automatic void text_step(input logic [7:0] c);
        if (c == CH_LT) begin
            if (sc_space && sc_run_text) put(CH_SPACE);
            put(c);
            sc_mode      = MODE_TAG;
            sc_quoted    = 1'b0;
            sc_name_len  = '0;
            sc_name_long = 1'b0;
            sc_name_ph   = PH_BEFORE;
            sc_closing   = 1'b0;
            sc_slash_end = 1'b0;
            sc_opener    = 3'd1;
            sc_after_tag = 1'b1;
            sc_space     = 1'b0;
            sc_run_text  = 1'b0;
        end else if (ws_byte(c)) begin
            sc_space = 1'b1;
        end else begin
            if (sc_space) put(CH_SPACE);
            put(c);
            sc_space    = 1'b0;
            sc_run_text = 1'b1;
        end
    endfunction

    function automatic void tag_step(input logic [7:0] c);
        logic just_opened;
        just_opened = (sc_opener == 3'd1);
        put(c);
        // track the "<!--" opener
        if (sc_opener >= 3'd1 && sc_opener <= 3'd3) begin
            if (c == ((sc_opener == 3'd1) ? CH_BANG : CH_DASH)) sc_opener++;
            else sc_opener = '0;
        end
        case (sc_name_ph)
            PH_BEFORE: begin
                if (just_opened && c == CH_SLASH) sc_closing = 1'b1;
                else if (ws_byte(c)) sc_closing = sc_closing;
                else if (name_byte(c)) begin
                    keep_name_byte(c);
                    sc_name_ph = PH_IN;
                end else sc_name_ph = PH_AFTER;
            end
            PH_IN: begin
                if (name_byte(c)) keep_name_byte(c);
                else sc_name_ph = PH_AFTER;
            end
            default: ;
        endcase
        if (sc_opener == 3'd4) begin
            sc_mode   = MODE_COMMENT;
            sc_dashes = '0;
            return;
        end
        if (sc_quoted) begin
            if (c == sc_quote_ch) sc_quoted = 1'b0;
        end else if (c == CH_DQ || c == CH_SQ) begin
            sc_quoted   = 1'b1;
            sc_quote_ch = c;
        end else if (c == CH_GT) begin
            close_tag();
            return;
        end
        if (!ws_byte(c)) sc_slash_end = (c == CH_SLASH);
    endfunction

    // Body of a preserved element: look for "</name" plus a delimiter
    function automatic void body_step(input logic [7:0] c);
        string nm;
        int    cnt;
        bit    ok;
        nm  = elem_name(sc_kind);
        cnt = sc_close_pos;
        put(c);
        if (cnt >= 2 + nm.len()) begin
            if (ws_byte(c) || c == CH_GT || c == CH_SLASH || c == CH_NUL) begin
                sc_close_pos = '0;
                if (c == CH_GT) begin
                    enter_text();
                    sc_kind = KIND_NONE;
                end else begin
                    sc_mode   = MODE_ENDTAG;
                    sc_quoted = 1'b0;
                end
                return;
            end
            cnt = (c == CH_LT);
        end else begin
            if (cnt == 0) ok = (c == CH_LT);
            else if (cnt == 1) ok = (c == CH_SLASH);
            else ok = (lower_byte(c) == nm[cnt - 2]);
            cnt = ok ? cnt + 1 : int'(c == CH_LT);
        end
        sc_close_pos = cnt[3:0];
    endfunction

    // Predict the results of one accepted byte and queue them
    function automatic void minify_byte(input logic [7:0] c, input logic doc_last);
        step_cnt = 0;
        case (sc_mode)
            MODE_TAG: tag_step(c);
            MODE_COMMENT: begin
                put(c);
                if (c == CH_DASH) begin
                    if (sc_dashes < 2) sc_dashes++;
                end else if (c == CH_GT && sc_dashes >= 2) enter_text();
                else sc_dashes = '0;
            end
            MODE_PRESERVE: body_step(c);
            MODE_ENDTAG: begin
                put(c);
                if (sc_quoted) begin
                    if (c == sc_quote_ch) sc_quoted = 1'b0;
                end else if (c == CH_DQ || c == CH_SQ) begin
                    sc_quoted   = 1'b1;
                    sc_quote_ch = c;
                end else if (c == CH_GT) begin
                    enter_text();
                    sc_kind = KIND_NONE;
                end
            end
            default: text_step(c);
        endcase
        if (doc_last) begin
            // trailing run survives if it follows text or no tag came at all
            if (sc_mode == MODE_TEXT && sc_space && (sc_run_text || !sc_after_tag))
                put(CH_SPACE);
            if (step_cnt == 0) begin
                step_outs[0] = '0;
                step_cnt     = 1;
            end
            step_outs[step_cnt - 1].doc_end = 1'b1;
        end
        if (step_cnt > 0) step_outs[step_cnt - 1].run_last = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            expected_out.insert(expected_out.size(), step_outs[i]);
        if (doc_last) reset_scanner();
    endfunction

    //--------------------------------------------------------------------
    // Monitor: predict on input transactions, check output transactions
    //--------------------------------------------------------------------
    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, actual %h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            reset_scanner();
        end else begin
            if (in_if.valid && in_if.ready) minify_byte(in_if.in_byte, in_if.doc_last);
            if (out_if.valid && out_if.ready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected result: out_byte %h out_valid %b run_last %b doc_end %b",
                           out_if.out_byte, out_if.out_valid, out_if.run_last,
                           out_if.doc_end);
                    mismatches++;
                end else begin
                    want = expected_out.pop_front();
                    check_field("out_byte", want.out_byte, out_if.out_byte);
                    check_field("out_valid", want.out_valid, out_if.out_valid);
                    check_field("run_last", want.run_last, out_if.run_last);
                    check_field("doc_end", want.doc_end, out_if.doc_end);
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // Output ready: random stalls, or a long hold when one is requested
    //--------------------------------------------------------------------
    initial begin
        out_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (holds_done != holds_asked) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else begin
                out_if.ready <= !(idle_on && $urandom_range(0, 99) < 7);
                @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    //--------------------------------------------------------------------
    // Input driving
    //--------------------------------------------------------------------
    // valid stays high after a transaction; the next call lowers it or reloads it
    task automatic send_byte(input logic [7:0] b, input logic doc_last);
        while (idle_on && $urandom_range(0, 99) < 7) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.in_byte  <= b;
        in_if.doc_last <= doc_last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_out.size() != 0) @(posedge i_clk);
    endtask

    // Send doc_q; pause_at >= 0 drains all results before that byte
    task automatic send_doc(input int pause_at);
        for (int i = 0; i < doc_q.size(); i++) begin
            if (i == pause_at) wait_for_results();
            send_byte(doc_q[i], i == doc_q.size() - 1);
        end
    endtask

    //--------------------------------------------------------------------
    // Document generation
    //--------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] c);
        doc_q.insert(doc_q.size(), c);
    endfunction

    function automatic logic [7:0] pick_from(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic void put_str(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c & 8'hdf;
            add_byte(c);
        end
    endfunction

    function automatic void put_ws_run();
        int code;
        repeat ($urandom_range(1, 3)) begin
            code = $urandom_range(8, 13);
            add_byte(code == 8 ? CH_SPACE : 8'(code));
        end
    endfunction

    function automatic void put_word();
        logic [7:0] c;
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 9) < 7) c = 8'("a" + $urandom_range(0, 25));
            else c = 8'($urandom_range(8'h21, 8'h7e));
            if (c == CH_LT) c = "x";
            if ($urandom_range(0, 3) == 0) c = lower_byte(c) ^ ((c >= "a" && c <= "z") ?
                                                                  8'h20 : 8'h00);
            add_byte(c);
        end
    endfunction

    function automatic void put_noise();
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_attrs();
        repeat ($urandom_range(0, 2)) begin
            add_byte($urandom_range(0, 3) == 0 ? 8'h0a : CH_SPACE);
            put_str("a", 1'b1);
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    add_byte("=");
                    put_word();
                end
                2: begin
                    add_byte("=");
                    add_byte(CH_DQ);
                    repeat ($urandom_range(0, 4)) add_byte(pick_from(">x /<='"));
                    add_byte(CH_DQ);
                end
                default: begin
                    add_byte("=");
                    add_byte(CH_SQ);
                    repeat ($urandom_range(0, 4)) add_byte(pick_from(">x /<=\""));
                    add_byte(CH_SQ);
                end
            endcase
        end
    endfunction

    // Ordinary, preserving, overlong and nameless tag names
    function automatic string pick_tag_name();
        case ($urandom_range(0, 13))
            0:       return "p";
            1:       return "div";
            2:       return "a-b";
            3:       return "h1:x";
            4:       return "pre";
            5:       return "code";
            6:       return "textarea";
            7:       return "script";
            8:       return "style";
            9:       return "textareas";
            10:      return "abcdefghij";
            11:      return "pr";
            12:      return "!x";
            default: return "";
        endcase
    endfunction

    function automatic void put_tag();
        add_byte(CH_LT);
        if ($urandom_range(0, 4) == 0) add_byte(CH_SLASH);
        if ($urandom_range(0, 7) == 0) add_byte(CH_SPACE);
        put_str(pick_tag_name(), 1'b1);
        put_attrs();
        if ($urandom_range(0, 4) == 0) add_byte(CH_SLASH);
        if ($urandom_range(0, 5) == 0) add_byte(CH_SPACE);
        add_byte(CH_GT);
    endfunction

    function automatic void put_comment();
        put_str("<!--", 1'b0);
        repeat ($urandom_range(0, 5)) add_byte(pick_from("->a <!"));
        if ($urandom_range(0, 3) == 0) put_str("--->", 1'b0);
        else put_str("-->", 1'b0);
    endfunction

    // Preserved element with near-miss close tags in its body
    function automatic void put_preserved();
        string nm;
        nm = elem_name(3'($urandom_range(KIND_PRE, KIND_STYLE)));
        add_byte(CH_LT);
        put_str(nm, 1'b1);
        put_attrs();
        add_byte(CH_GT);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: put_str(nm.substr($urandom_range(0, nm.len() - 1),
                                           nm.len() - 1), 1'b1);
                3:       add_byte(CH_LT);
                4:       add_byte(CH_SLASH);
                5:       add_byte(CH_SPACE);
                6:       add_byte(CH_GT);
                7: begin
                    put_str("</", 1'b0);
                    put_str(nm.substr(0, $urandom_range(0, nm.len() - 1)), 1'b1);
                end
                8: begin
                    put_str("</", 1'b0);
                    put_str(nm, 1'b1);
                    add_byte("x");
                end
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
        put_str("</", 1'b0);
        put_str(nm, 1'b1);
        case ($urandom_range(0, 4))
            0:       add_byte(CH_GT);
            1:       add_byte(CH_SPACE);
            2:       add_byte(CH_SLASH);
            3:       add_byte(CH_NUL);
            default: add_byte(8'h09);
        endcase
        if (doc_q[$] != CH_GT) begin
            put_attrs();
            add_byte(CH_GT);
        end
    endfunction

    // Mostly well-formed documents; some noise and some cut short
    function automatic void make_doc();
        int keep;
        doc_q.delete();
        repeat ($urandom_range(1, 9)) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3:       put_ws_run();
                4, 5, 6, 7:       put_word();
                8, 9, 10, 11, 12: put_tag();
                13, 14:           put_comment();
                15, 16, 17:       put_preserved();
                default:          put_noise();
            endcase
        end
        if ($urandom_range(0, 9) == 0 && doc_q.size() > 1) begin
            keep = $urandom_range(1, doc_q.size() - 1);
            while (doc_q.size() > keep) doc_q.delete(doc_q.size() - 1);
        end
    endfunction

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------
    // Byte extremes, all whitespace kinds, end marker, case-blind body, comment
    task automatic test_directed();
        doc_q.delete();
        add_byte(CH_NUL);
        add_byte(CH_SPACE);
        for (int c = 9; c <= 13; c++) add_byte(8'(c));
        add_byte(8'hff);
        send_doc(-1);
        doc_q.delete();
        put_str("<p> ", 1'b0);
        send_doc(-1);
        doc_q.delete();
        put_str("<PRE> </pre>", 1'b0);
        send_doc(-1);
        doc_q.delete();
        put_str(" ", 1'b0);
        send_doc(-1);
        doc_q.delete();
        put_str("<!---->", 1'b0);
        send_doc(-1);
    endtask

    task automatic test_no_idle();
        int stop_at;
        idle_on = 1'b0;
        stop_at = bytes_sent + 150;
        while (bytes_sent < stop_at) begin
            make_doc();
            send_doc(-1);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_docs();
        int stop_at;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) begin
            make_doc();
            send_doc(-1);
        end
    endtask

    // Receiver holds off while the sender keeps offering bytes
    task automatic test_output_hold();
        holds_asked++;
        repeat (3) begin
            make_doc();
            send_doc(-1);
        end
    endtask

    // Sender stops mid-document until every result is out
    task automatic test_drain_pause();
        repeat (4) begin
            make_doc();
            send_doc($urandom_range(0, doc_q.size() - 1));
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_if.valid    = 1'b0;
        in_if.in_byte  = '0;
        in_if.doc_last = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_no_idle();
        test_random_docs();
        test_output_hold();
        test_drain_pause();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
src/hwm_pkg.sv
src/hwm_in_if.sv
src/hwm_out_if.sv
src/hwm_parser.sv
src/hwm_outq.sv
src/html_whitespace_minifier.sv
src/hwm_checker.sv
tb/tb_html_whitespace_minifier.sv
